// ===== src/sfb_pkg.sv =====
// Package for the structure function binner: field widths, sizes, codes and
// the item and result struct types. No dependencies.
`timescale 1ns / 1ps

package sfb_pkg;

    localparam int COORD_BITS   = 10;
    localparam int NUM_BINS     = 2048;
    localparam int ADDR_BITS    = $clog2(NUM_BINS);

    localparam int BIN_BITS     = 11;
    localparam int REG_BITS     = 11;
    localparam int VALUE_BITS   = 16;
    localparam int MAG_BITS     = VALUE_BITS;
    localparam int SQ_BITS      = 2 * MAG_BITS;
    localparam int CSQ_BITS     = 2 * COORD_BITS;
    localparam int D2_BITS      = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS    = COORD_BITS + 1;
    localparam int SUM_BITS     = 48;
    localparam int COUNT_BITS   = 32;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT = 1'b1;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [REG_BITS-1:0] MAP_SIZE_RESET = REG_BITS'(1024);

    typedef struct packed {
        logic                         op;
        logic [COORD_BITS-1:0]        x_a;
        logic [COORD_BITS-1:0]        y_a;
        logic signed [VALUE_BITS-1:0] value_a;
        logic [COORD_BITS-1:0]        x_b;
        logic [COORD_BITS-1:0]        y_b;
        logic signed [VALUE_BITS-1:0] value_b;
        logic [BIN_BITS-1:0]          bin_index;
    } sfb_item_t;

    typedef struct packed {
        logic [BIN_BITS-1:0]   bin;
        logic [SUM_BITS-1:0]   bin_sum;
        logic [COUNT_BITS-1:0] bin_count;
        logic                  out_of_map;
        logic                  saturated;
    } sfb_result_t;

endpackage

// ===== src/sfb_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/sfb_isqrt.sv =====
// Iterative integer square root, one result bit per cycle (restoring method).
// Depends on sfb_pkg.
`timescale 1ns / 1ps

module sfb_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [sfb_pkg::D2_BITS-1:0]   radicand,
    output logic                          done,
    output logic [sfb_pkg::ROOT_BITS-1:0] root
);
    import sfb_pkg::*;

    localparam int PAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 3;
    localparam int STEP_BITS = $clog2(ROOT_BITS + 1);

    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [STEP_BITS-1:0] steps_reg, steps_next;
    logic [PAD_BITS-1:0]  rad_reg, rad_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;

    logic [REM_BITS-1:0]  shifted;
    logic [REM_BITS-1:0]  trial;

    assign shifted = {rem_reg[REM_BITS-3:0], rad_reg[PAD_BITS-1 -: 2]};
    assign trial   = REM_BITS'({root_reg, 2'b01});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        steps_next  = steps_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        if (load)
        begin
            active_next = 1'b1;
            steps_next  = STEP_BITS'(ROOT_BITS);
            rad_next    = PAD_BITS'(radicand);
            rem_next    = '0;
            root_next   = '0;
        end
        else if (active_reg)
        begin
            rad_next   = {rad_reg[PAD_BITS-3:0], 2'b00};
            steps_next = steps_reg - 1'b1;
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
            end
            if (steps_reg == STEP_BITS'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            steps_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            steps_reg  <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/structure_function_binner_core.sv =====
// Top level of the structure function binner: control sequencer, datapath
// and the two bin stores. Depends on sfb_pkg, sfb_ram and sfb_isqrt.
`timescale 1ns / 1ps

//  channel   ports                              transfer
//  ------    -----                              --------
//  item      start, busy, item                  start high while busy low
//  result    result_valid, result               one cycle, result_valid high
//  config    cfg_we, cfg_index, cfg_data        cfg_we high, no wait
//
//  After reset both stores are swept to zero, one bin a cycle, over all
//  NUM_BINS (2048) bins; busy stays high meanwhile.
//  Read item: the store is read at the transfer, then S_RD registers the result.
//  Accumulate item: setup in S_MUL (square) and S_ADD (sum), then the square
//  root unit finds the ROOT_BITS (11) root bits until it signals done, then a
//  read and a write-back of the bin. Rejected pairs give their result from
//  S_ROOT and skip the read and write-back.
//  One item is in flight at a time; the result receiver cannot stall.

module structure_function_binner_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sfb_pkg::sfb_item_t             item,
    output logic                           result_valid,
    output sfb_pkg::sfb_result_t           result,
    input  logic                           cfg_we,
    input  logic [sfb_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [sfb_pkg::REG_BITS-1:0]   cfg_data
);
    import sfb_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_WB    = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic [REG_BITS-1:0]   map_width_reg, map_height_reg;
    logic                  result_valid_reg, result_valid_next;
    sfb_result_t           result_reg, result_next;

    // item datapath
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [MAG_BITS-1:0]   mag_reg, mag_next;
    logic                  oom_reg, oom_next;
    logic [CSQ_BITS-1:0]   dxsq_reg, dysq_reg;
    logic [SQ_BITS-1:0]    magsq_reg;
    logic [BIN_BITS-1:0]   idx_reg, idx_next;
    logic                  idx_oob_reg, idx_oob_next;
    logic [ADDR_BITS-1:0]  bin_addr_reg, bin_addr_next;

    logic signed [VALUE_BITS:0] dv;
    logic                  accept;
    logic                  in_map;
    logic                  root_oob;

    // store ports
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [SUM_BITS-1:0]   sum_wr;
    logic [COUNT_BITS-1:0] count_wr;
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [SUM_BITS-1:0]   sum_rd;
    logic [COUNT_BITS-1:0] count_rd;

    // root unit
    logic                  sq_load;
    logic                  sq_done;
    logic [ROOT_BITS-1:0]  sq_root;
    logic [D2_BITS-1:0]    d2;

    // write-back arithmetic
    logic [SUM_BITS:0]     sum_ext;
    logic [SUM_BITS-1:0]   sum_new;
    logic [COUNT_BITS-1:0] count_new;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    assign in_map = (32'(item.x_a) < 32'(map_width_reg))
                 && (32'(item.x_b) < 32'(map_width_reg))
                 && (32'(item.y_a) < 32'(map_height_reg))
                 && (32'(item.y_b) < 32'(map_height_reg));

    assign dv = $signed({item.value_a[VALUE_BITS-1], item.value_a})
              - $signed({item.value_b[VALUE_BITS-1], item.value_b});

    assign d2       = D2_BITS'(dxsq_reg) + D2_BITS'(dysq_reg);
    assign root_oob = (32'(sq_root) >= 32'(NUM_BINS));

    assign sum_ext   = {1'b0, sum_rd} + (SUM_BITS + 1)'(magsq_reg);
    assign sum_new   = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
    assign count_new = (&count_rd) ? count_rd : count_rd + 1'b1;

    sfb_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (NUM_BINS)
    ) u_sum_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sum_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (sum_rd)
    );

    sfb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_count_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (count_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (count_rd)
    );

    sfb_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (sq_load),
        .radicand (d2),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        mag_next          = mag_reg;
        oom_next          = oom_reg;
        idx_next          = idx_reg;
        idx_oob_next      = idx_oob_reg;
        bin_addr_next     = bin_addr_reg;
        wr_en             = 1'b0;
        wr_addr           = bin_addr_reg;
        sum_wr            = sum_new;
        count_wr          = count_new;
        rd_en             = 1'b0;
        rd_addr           = bin_addr_reg;
        sq_load           = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                sum_wr        = '0;
                count_wr      = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_BITS'(NUM_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_READ)
                    begin
                        idx_next      = item.bin_index;
                        idx_oob_next  = (32'(item.bin_index) >= 32'(NUM_BINS));
                        rd_en         = 1'b1;
                        rd_addr       = ADDR_BITS'(item.bin_index);
                        state_next    = S_RD;
                    end
                    else
                    begin
                        dx_next    = (item.x_a > item.x_b) ? item.x_a - item.x_b
                                                           : item.x_b - item.x_a;
                        dy_next    = (item.y_a > item.y_b) ? item.y_a - item.y_b
                                                           : item.y_b - item.y_a;
                        mag_next   = dv[VALUE_BITS] ? MAG_BITS'(-dv) : MAG_BITS'(dv);
                        oom_next   = !in_map;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                sq_load    = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sq_done)
                begin
                    if (oom_reg || root_oob)
                    begin
                        result_valid_next      = 1'b1;
                        result_next.bin        = '0;
                        result_next.bin_sum    = '0;
                        result_next.bin_count  = '0;
                        result_next.out_of_map = 1'b1;
                        result_next.saturated  = 1'b0;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        bin_addr_next = ADDR_BITS'(sq_root);
                        rd_en         = 1'b1;
                        rd_addr       = ADDR_BITS'(sq_root);
                        state_next    = S_WB;
                    end
                end
            end
            S_RD:
            begin
                result_valid_next      = 1'b1;
                result_next.bin        = idx_reg;
                result_next.out_of_map = 1'b0;
                if (idx_oob_reg)
                begin
                    result_next.bin_sum   = '0;
                    result_next.bin_count = '0;
                    result_next.saturated = 1'b0;
                end
                else
                begin
                    result_next.bin_sum   = sum_rd;
                    result_next.bin_count = count_rd;
                    result_next.saturated = (&sum_rd) || (&count_rd);
                end
                state_next = S_IDLE;
            end
            S_WB:
            begin
                // store read back last cycle; no other access can intervene
                wr_en                  = 1'b1;
                result_valid_next      = 1'b1;
                result_next.bin        = BIN_BITS'(bin_addr_reg);
                result_next.bin_sum    = sum_new;
                result_next.bin_count  = count_new;
                result_next.out_of_map = 1'b0;
                result_next.saturated  = (&sum_new) || (&count_new);
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
            map_width_reg    <= MAP_SIZE_RESET;
            map_height_reg   <= MAP_SIZE_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we && (cfg_index == CFG_MAP_WIDTH))
            begin
                map_width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_MAP_HEIGHT))
            begin
                map_height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        mag_reg      <= mag_next;
        oom_reg      <= oom_next;
        idx_reg      <= idx_next;
        idx_oob_reg  <= idx_oob_next;
        bin_addr_reg <= bin_addr_next;
        dxsq_reg     <= CSQ_BITS'(dx_reg) * CSQ_BITS'(dx_reg);
        dysq_reg     <= CSQ_BITS'(dy_reg) * CSQ_BITS'(dy_reg);
        magsq_reg    <= SQ_BITS'(mag_reg) * SQ_BITS'(mag_reg);
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy)
        else $error("item could be taken during the clearing sweep");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_WB) || (state_reg == S_CLEAR)))
        else $error("store written outside write-back or clearing");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after an item transfer");

    a_oom_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_of_map) |->
            ((result.bin == '0) && (result.bin_sum == '0) && !result.saturated))
        else $error("rejected pair result carries bin data");

    a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (state_reg == S_IDLE))
        else $error("result strobe while an item is still in flight");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for structure_function_binner_core: a queue-fed driver, a result
// monitor and a bin store predictor beside the block. Depends on sfb_pkg and the core.
`timescale 1ns / 1ps

module testbench;

    import sfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 40;

    localparam logic [SUM_BITS-1:0]   SUM_FULL   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

    typedef struct packed {
        step_kind_t                kind;
        sfb_item_t                 item;
        logic [CFG_IDX_BITS-1:0]   reg_index;
        logic [REG_BITS-1:0]       reg_value;
    } step_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    sfb_item_t               item = '0;
    logic                    result_valid;
    sfb_result_t             result;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]     cfg_data = '0;

    step_t       pending_steps[$];
    sfb_result_t bin_outcomes_due[$];
    sfb_result_t want_result;

    // predictor copy of the block's state
    logic [SUM_BITS-1:0]   acc_sum   [NUM_BINS] = '{default: '0};
    logic [COUNT_BITS-1:0] acc_count [NUM_BINS] = '{default: '0};
    logic [REG_BITS-1:0]   map_cols = MAP_SIZE_RESET;
    logic [REG_BITS-1:0]   map_rows = MAP_SIZE_RESET;

    int mismatches      = 0;
    int items_sent      = 0;
    int reads_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int quiet_cycles    = 0;
    int stalled_cycles  = 0;
    logic write_now;

    structure_function_binner_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // truncated square root of the squared pixel distance
    function automatic int unsigned pair_bin(input logic [COORD_BITS-1:0] xa, ya, xb, yb);
        int unsigned dx, dy, d2, root, trial;
        dx = (xa > xb) ? 32'(xa) - 32'(xb) : 32'(xb) - 32'(xa);
        dy = (ya > yb) ? 32'(ya) - 32'(yb) : 32'(yb) - 32'(ya);
        d2 = dx * dx + dy * dy;
        root = 0;
        for (int b = COORD_BITS + 1; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= d2)
                root = trial;
        end
        return root;
    endfunction

    // applies one transfer to the bin stores and returns the result it must produce
    function automatic sfb_result_t bin_outcome(input sfb_item_t it);
        sfb_result_t       r;
        int unsigned       b;
        shortint           va, vb;
        int                dv;
        longint unsigned   sq;
        logic [SUM_BITS:0] total;
        r = '0;
        if (it.op == OP_READ)
        begin
            r.bin = it.bin_index;
            r.bin_sum = acc_sum[it.bin_index];
            r.bin_count = acc_count[it.bin_index];
            r.saturated = (r.bin_sum == SUM_FULL) || (r.bin_count == COUNT_FULL);
            return r;
        end
        if ({1'b0, it.x_a} >= map_cols || {1'b0, it.x_b} >= map_cols ||
            {1'b0, it.y_a} >= map_rows || {1'b0, it.y_b} >= map_rows)
        begin
            r.out_of_map = 1'b1;
            return r;
        end
        b = pair_bin(it.x_a, it.y_a, it.x_b, it.y_b);
        if (b >= NUM_BINS)
        begin
            r.out_of_map = 1'b1;
            return r;
        end
        va = it.value_a;
        vb = it.value_b;
        dv = int'(va) - int'(vb);
        if (dv < 0)
            dv = -dv;
        sq = longint'(dv) * longint'(dv);
        total = {1'b0, acc_sum[b]} + (SUM_BITS + 1)'(sq);
        acc_sum[b] = total[SUM_BITS] ? SUM_FULL : total[SUM_BITS-1:0];
        if (acc_count[b] != COUNT_FULL)
            acc_count[b] = acc_count[b] + 1'b1;
        r.bin = b[BIN_BITS-1:0];
        r.bin_sum = acc_sum[b];
        r.bin_count = acc_count[b];
        r.saturated = (acc_sum[b] == SUM_FULL) || (acc_count[b] == COUNT_FULL);
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    function automatic sfb_item_t pair_item(input int xa, ya, va, xb, yb, vb);
        sfb_item_t it;
        it = '0;
        it.op = OP_ACCUM;
        it.x_a = COORD_BITS'(xa);
        it.y_a = COORD_BITS'(ya);
        it.value_a = VALUE_BITS'(va);
        it.x_b = COORD_BITS'(xb);
        it.y_b = COORD_BITS'(yb);
        it.value_b = VALUE_BITS'(vb);
        return it;
    endfunction

    function automatic sfb_item_t read_item(input int idx);
        sfb_item_t it;
        it = '0;
        it.op = OP_READ;
        it.bin_index = BIN_BITS'(idx);
        return it;
    endfunction

    // half the time anywhere in the map, otherwise close to the other pixel
    function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] c,
                                                         input int unsigned lim);
        int v;
        if ($urandom_range(0, 1) == 0)
            return COORD_BITS'($urandom_range(0, lim - 1));
        v = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > int'(lim) - 1)
            v = int'(lim) - 1;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pixel_value();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
        return VALUE_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic sfb_item_t random_pair(input int unsigned w, input int unsigned h);
        sfb_item_t   it;
        int unsigned cols, rows;
        cols = (w == 0 || w > 1024) ? 1024 : w;
        rows = (h == 0 || h > 1024) ? 1024 : h;
        it.op = OP_ACCUM;
        it.x_a = COORD_BITS'($urandom_range(0, cols - 1));
        it.y_a = COORD_BITS'($urandom_range(0, rows - 1));
        it.x_b = near_coord(it.x_a, cols);
        it.y_b = near_coord(it.y_a, rows);
        it.value_a = pixel_value();
        it.value_b = pixel_value();
        it.bin_index = BIN_BITS'($urandom_range(0, NUM_BINS - 1));
        return it;
    endfunction

    task automatic queue_item(input sfb_item_t it);
        pending_steps.push_back(step_t'{STEP_ITEM, it, '0, '0});
    endtask

    task automatic queue_reg_write(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        pending_steps.push_back(step_t'{STEP_CFG, sfb_item_t'('0), idx, value[REG_BITS-1:0]});
    endtask

    // mostly in-map pairs, some off-map noise, reads biased towards touched bins
    task automatic add_random_phase(input int n, input int unsigned w, input int unsigned h);
        sfb_item_t   it;
        int unsigned roll, recent;
        recent = 0;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            it = random_pair(w, h);
            if (roll < 65)
                recent = pair_bin(it.x_a, it.y_a, it.x_b, it.y_b);
            else if (roll < 75)
            begin
                it.x_a = COORD_BITS'($urandom_range(0, 1023));
                it.y_a = COORD_BITS'($urandom_range(0, 1023));
                it.x_b = COORD_BITS'($urandom_range(0, 1023));
                it.y_b = COORD_BITS'($urandom_range(0, 1023));
            end
            else
            begin
                it.op = OP_READ;
                case ($urandom_range(0, 2))
                    0:       it.bin_index = BIN_BITS'(recent);
                    1:       it.bin_index = BIN_BITS'($urandom_range(0, 40));
                    default: it.bin_index = BIN_BITS'($urandom_range(0, NUM_BINS - 1));
                endcase
            end
            queue_item(it);
        end
    endtask

    // driver: presents queued items, writes registers only once the block is quiet
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            write_now = 1'b0;
            if (start && !busy)
            begin
                bin_outcomes_due.push_back(bin_outcome(item));
                items_sent++;
                if (item.op == OP_READ)
                    reads_sent++;
            end
            if (!busy && !start && bin_outcomes_due.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (start && busy)
            begin
                // item still waiting for its transfer
            end
            else if (pending_steps.size() == 0)
                start <= 1'b0;
            else if (pending_steps[0].kind == STEP_ITEM)
            begin
                if (!(items_sent >= 250 && items_sent < 350) && $urandom_range(0, 99) < 24)
                    start <= 1'b0;
                else
                begin
                    item <= pending_steps[0].item;
                    start <= 1'b1;
                    void'(pending_steps.pop_front());
                end
            end
            else
            begin
                start <= 1'b0;
                if (quiet_cycles >= SETTLE_CYCLES)
                begin
                    if (pending_steps[0].kind == STEP_CFG)
                    begin
                        write_now = 1'b1;
                        cfg_index <= pending_steps[0].reg_index;
                        cfg_data <= pending_steps[0].reg_value;
                        if (pending_steps[0].reg_index == CFG_MAP_WIDTH)
                            map_cols = pending_steps[0].reg_value;
                        else
                            map_rows = pending_steps[0].reg_value;
                        reg_writes++;
                    end
                    void'(pending_steps.pop_front());
                end
            end
            cfg_we <= write_now;
        end
    end

    // monitor: every strobed result against the oldest outstanding prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (bin_outcomes_due.size() == 0)
            begin
                $error("result with no transfer outstanding: bin %0d", result.bin);
                mismatches++;
            end
            else
            begin
                want_result = bin_outcomes_due.pop_front();
                check_field("bin", 64'(want_result.bin), 64'(result.bin));
                check_field("bin_sum", 64'(want_result.bin_sum), 64'(result.bin_sum));
                check_field("bin_count", 64'(want_result.bin_count),
                            64'(result.bin_count));
                check_field("out_of_map", 64'(want_result.out_of_map),
                            64'(result.out_of_map));
                check_field("saturated", 64'(want_result.saturated),
                            64'(result.saturated));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("structure_function_binner_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int unsigned w, h;

        // reset sizes: edge pixels, extreme values, exact and truncated roots
        queue_item(read_item(0));
        queue_item(pair_item(0, 0, 0, 0, 0, 0));
        queue_item(pair_item(0, 0, 32767, 1023, 1023, -32768));
        queue_item(pair_item(1023, 1023, -32768, 0, 0, 32767));
        queue_item(pair_item(1023, 0, -32768, 0, 1023, -32768));
        queue_item(pair_item(0, 0, -1, 3, 4, 1));
        queue_item(pair_item(2, 2, 100, 0, 0, -100));
        queue_item(pair_item(0, 1023, 12345, 0, 0, -12345));
        queue_item(pair_item(1023, 512, 32767, 1023, 512, 32767));
        queue_item(read_item(1446));
        queue_item(read_item(0));
        queue_item(read_item(5));
        queue_item(read_item(2047));
        queue_item(read_item(1023));
        add_random_phase(75, 1024, 1024);
        pending_steps.push_back(step_t'{STEP_DRAIN, sfb_item_t'('0), '0, '0});
        add_random_phase(75, 1024, 1024);

        // sizes above the coordinate range accept every pixel
        queue_reg_write(CFG_MAP_WIDTH, 2047);
        queue_reg_write(CFG_MAP_HEIGHT, 2047);
        queue_item(pair_item(1023, 1023, 7, 0, 0, -7));
        add_random_phase(100, 2047, 2047);

        // single-pixel map
        queue_reg_write(CFG_MAP_WIDTH, 1);
        queue_reg_write(CFG_MAP_HEIGHT, 1);
        queue_item(pair_item(0, 0, 5, 0, 0, -5));
        queue_item(pair_item(1, 0, 5, 0, 0, -5));
        queue_item(pair_item(0, 0, 5, 0, 1, -5));
        queue_item(read_item(0));
        add_random_phase(30, 1, 1);

        // zero width rejects everything
        queue_reg_write(CFG_MAP_WIDTH, 0);
        queue_reg_write(CFG_MAP_HEIGHT, 1024);
        queue_item(pair_item(0, 0, 1, 0, 0, 2));
        add_random_phase(20, 0, 1024);

        w = $urandom_range(2, 1023);
        h = $urandom_range(2, 1023);
        queue_reg_write(CFG_MAP_WIDTH, w);
        queue_reg_write(CFG_MAP_HEIGHT, h);
        add_random_phase(100, w, h);

        w = $urandom_range(1025, 2046);
        h = $urandom_range(2, 1023);
        queue_reg_write(CFG_MAP_WIDTH, w);
        queue_reg_write(CFG_MAP_HEIGHT, h);
        add_random_phase(100, w, h);

        queue_reg_write(CFG_MAP_WIDTH, 1024);
        queue_reg_write(CFG_MAP_HEIGHT, 1024);
        add_random_phase(30, 1024, 1024);

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // sample away from the active edge so the driver's updates have settled
        while (pending_steps.size() != 0 || start || bin_outcomes_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d transfers (%0d reads), %0d results checked, %0d register writes",
                 items_sent, reads_sent, results_checked, reg_writes);
        $display("map sizes: reset, oversized, 1x1, zero width, two random shapes");
        if (mismatches == 0)
            $display("structure_function_binner_core: match");
        else
            $display("structure_function_binner_core: mismatch");
        $finish;
    end

endmodule

// ===== structure_function_binner_core.f =====
src/sfb_pkg.sv
src/sfb_ram.sv
src/sfb_isqrt.sv
src/structure_function_binner_core.sv
tb/testbench.sv
